>>> rtl/segmented_colormap_rgb_unit_assert.svh
// ----------------------------------------------------------------------------
// Segmented colormap assertion macros
// Clocked on aclk, quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_COLORMAP_RGB_UNIT_ASSERT_SVH
`define SEGMENTED_COLORMAP_RGB_UNIT_ASSERT_SVH

// same-cycle implication
`define SCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, codes and types of the segmented colormap.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    localparam int MAX_POINTS_DEF = 32;

    localparam int X_W     = 17;  // Q1.16 position / fraction
    localparam int Y_W     = 24;  // Q8.16 stored value
    localparam int SCALE_W = 8;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 5;
    localparam int CH_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int FRAC_W  = 16;
    localparam int DY_W    = Y_W + 1;
    localparam int DX_W    = X_W + 1;
    localparam int NUM_W   = DY_W + DX_W;
    localparam int Q_W     = 25;  // quotient bits kept before saturation
    localparam int V_W     = Y_W + 3;
    localparam int SDATA_W = 80;
    localparam int MDATA_W = 24;
    localparam int CFG_D_W = 8;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        CFG_SCALE = 2'd0,
        CFG_RED   = 2'd1,
        CFG_GREEN = 2'd2,
        CFG_BLUE  = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_t;

    // per-stage control travelling with each word
    typedef struct packed {
        logic vld;
        logic eval;
        logic wr;
    } ctl_t;

endpackage

`default_nettype wire

>>> rtl/segmented_colormap_rgb_unit.sv
// ----------------------------------------------------------------------------
// segmented_colormap_rgb_unit
// Scalar to packed RGB through three piecewise linear breakpoint tables.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per request. tuser selects load or evaluate. A load
//   writes one breakpoint (y values scaled by value_scale, saturated to
//   24 bits) and gives no result; an evaluate gives one packed colour word
//   on the m_ channel. Loads and evaluates may be mixed freely: an evaluate
//   always sees every load accepted before it.
//   cfg_ channel: register writes (scale, point counts), always ready; write
//   only while no word is in flight.
//   Throughput: one word per cycle while not stalled. Depth: 33 register
//   stages: the capture stage, five search, table read, subtract and
//   multiply stages, the divider set-up plus its 25 bit stages in each
//   channel, and the output register.
//   Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
//   s_tready drops in the same cycle, nothing is lost or repeated.
//   Reset: clears all valid bits and the registers to scale 255, one point
//   per channel. Breakpoint tables hold no reset value; read only after load.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segmented_colormap_rgb_unit_assert.svh"

module segmented_colormap_rgb_unit
    import scm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [1:0] channel, [6:2] point_index, [23:7] point_x, [40:24] point_y_left,
    // [57:41] point_y_right, [74:58] sample_x, [79:75] zero
    input  wire logic [SDATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic [0:0]         s_tuser,
    // result words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [23:0] color (red 23..16, green 15..8, blue 7..0)
    output logic [MDATA_W-1:0]      m_tdata,
    // register writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_D_W-1:0] cfg_data
);

    logic en;

    // configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [CNT_W-1:0]   red_pts_reg, green_pts_reg, blue_pts_reg;

    // first stage: captured word
    ctl_t             ctl1_reg;
    req_t             req1_reg;
    logic [CH_W-1:0]  ch1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [X_W-1:0]   x1_reg, yl1_reg, yr1_reg, sx1_reg;
    logic             idx_ok;

    // y scaling: product, then saturated
    logic [Y_W:0]     ylm2_reg, yrm2_reg;
    logic [Y_W-1:0]   yl3_reg, yr3_reg;

    ctl_t             ctl_r, ctl_g, ctl_b;
    ctl_t             in_r, in_g, in_b;
    logic [BYTE_W-1:0] byte_r, byte_g, byte_b;

    // whole pipeline moves together; last stage doubles as output register
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_W'(255);
            red_pts_reg   <= CNT_W'(1);
            green_pts_reg <= CNT_W'(1);
            blue_pts_reg  <= CNT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCALE: scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_RED:   red_pts_reg   <= cfg_data[CNT_W-1:0];
                CFG_GREEN: green_pts_reg <= cfg_data[CNT_W-1:0];
                CFG_BLUE:  blue_pts_reg  <= cfg_data[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else if (en) begin
            ctl1_reg.vld  <= s_tvalid;
            ctl1_reg.eval <= s_tvalid && (req_t'(s_tuser[0]) == REQ_EVAL);
            ctl1_reg.wr   <= 1'b0;
        end
        if (en) begin
            req1_reg <= req_t'(s_tuser[0]);
            ch1_reg  <= s_tdata[1:0];
            idx1_reg <= s_tdata[6:2];
            x1_reg   <= s_tdata[23:7];
            yl1_reg  <= s_tdata[40:24];
            yr1_reg  <= s_tdata[57:41];
            sx1_reg  <= s_tdata[74:58];
        end
    end

    // loads past the table end or to channel three fall away
    assign idx_ok = 32'(idx1_reg) < MAX_POINTS;

    always_comb begin
        logic ld;
        ld = ctl1_reg.vld && (req1_reg == REQ_LOAD) && idx_ok;
        in_r = ctl1_reg;
        in_g = ctl1_reg;
        in_b = ctl1_reg;
        in_r.wr = ld && (ch1_reg == CH_RED);
        in_g.wr = ld && (ch1_reg == CH_GREEN);
        in_b.wr = ld && (ch1_reg == CH_BLUE);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ylm2_reg <= yl1_reg * scale_reg;
            yrm2_reg <= yr1_reg * scale_reg;
            yl3_reg  <= ylm2_reg[Y_W] ? '1 : ylm2_reg[Y_W-1:0];
            yr3_reg  <= yrm2_reg[Y_W] ? '1 : yrm2_reg[Y_W-1:0];
        end
    end

    scm_channel #(.MAX_POINTS(MAX_POINTS)) u_red (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctl     (in_r),
        .in_idx     (idx1_reg),
        .in_x       (x1_reg),
        .in_sx      (sx1_reg),
        .points     (red_pts_reg),
        .y_left_s3  (yl3_reg),
        .y_right_s3 (yr3_reg),
        .out_ctl    (ctl_r),
        .out_byte   (byte_r)
    );

    scm_channel #(.MAX_POINTS(MAX_POINTS)) u_green (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctl     (in_g),
        .in_idx     (idx1_reg),
        .in_x       (x1_reg),
        .in_sx      (sx1_reg),
        .points     (green_pts_reg),
        .y_left_s3  (yl3_reg),
        .y_right_s3 (yr3_reg),
        .out_ctl    (ctl_g),
        .out_byte   (byte_g)
    );

    scm_channel #(.MAX_POINTS(MAX_POINTS)) u_blue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctl     (in_b),
        .in_idx     (idx1_reg),
        .in_x       (x1_reg),
        .in_sx      (sx1_reg),
        .points     (blue_pts_reg),
        .y_left_s3  (yl3_reg),
        .y_right_s3 (yr3_reg),
        .out_ctl    (ctl_b),
        .out_byte   (byte_b)
    );

    assign m_tvalid = ctl_r.vld && ctl_r.eval;
    assign m_tdata  = {byte_r, byte_g, byte_b};

    // the three channel pipelines must stay in lock step
    `SCM_ASSERT_IMP(a_lanes_aligned, ctl_r.vld || ctl_g.vld || ctl_b.vld,
        (ctl_r.vld == ctl_g.vld) && (ctl_g.vld == ctl_b.vld) &&
        (ctl_r.eval == ctl_g.eval) && (ctl_g.eval == ctl_b.eval),
        "channel pipelines out of step")
    `SCM_ASSERT_IMP(a_reset_quiet, $rose(aresetn), !m_tvalid,
        "result word straight after reset")
    `SCM_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed under stall")

endmodule

`default_nettype wire

>>> rtl/scm_channel.sv
// ----------------------------------------------------------------------------
// scm_channel
// One colour channel: breakpoint search, table read, interpolation, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_channel
    import scm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire ctl_t              in_ctl,     // first stage
    input  wire logic [IDX_W-1:0]  in_idx,
    input  wire logic [X_W-1:0]    in_x,
    input  wire logic [X_W-1:0]    in_sx,
    input  wire logic [CNT_W-1:0]  points,
    input  wire logic [Y_W-1:0]    y_left_s3,  // scaled, third stage
    input  wire logic [Y_W-1:0]    y_right_s3,
    output ctl_t                   out_ctl,
    output logic [BYTE_W-1:0]      out_byte
);

    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // position cells, compared in parallel
    logic [X_W-1:0] x_cell_reg [MAX_POINTS];
    logic [X_W-1:0] x_mem  [MAX_POINTS];
    logic [Y_W-1:0] yl_mem [MAX_POINTS];
    logic [Y_W-1:0] yr_mem [MAX_POINTS];

    ctl_t                  ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;
    logic [MAX_POINTS-1:0] gt2_reg, gt2_next;
    logic [X_W-1:0]        sx2_reg, sx3_reg, sx4_reg, x2_reg, x3_reg;
    logic [IDX_W-1:0]      idx2_reg, idx3_reg;
    logic [PW-1:0]         i3_reg, i3_next, a1;
    logic                  last3_reg, last3_next, last4_reg, last5_reg, last6_reg;
    logic [X_W-1:0]        x0_4_reg, x1_4_reg;
    logic [Y_W-1:0]        yl4_reg, yr4_reg, yr5_reg, yr6_reg;
    logic signed [DY_W-1:0]  dy5_reg;
    logic signed [DX_W-1:0]  dx5_reg, d5_reg, d6_reg;
    logic signed [NUM_W-1:0] num6_reg;
    logic [CW-1:0]         n_eff;

    // divider stages, index 0 is the set-up stage
    ctl_t             dctl_reg  [Q_W+1];
    logic [NUM_W-1:0] rem_reg   [Q_W+1];
    logic [DX_W-1:0]  den_reg   [Q_W+1];
    logic [Q_W-1:0]   quo_reg   [Q_W+1];
    logic             neg_reg   [Q_W+1];
    logic             sat_reg   [Q_W+1];
    logic             skip_reg  [Q_W+1];
    logic [Y_W-1:0]   dyr_reg   [Q_W+1];

    ctl_t              ctlo_reg;
    logic [BYTE_W-1:0] byte_reg, byte_next;

    // count in use, clamped to 1..MAX_POINTS
    always_comb begin
        if (points == '0) begin
            n_eff = CW'(1);
        end else if (32'(points) > MAX_POINTS) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = CW'(points);
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_ctl.wr) begin
            x_cell_reg[PW'(in_idx)] <= in_x;
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_POINTS; j++) begin
            gt2_next[j] = x_cell_reg[j] > in_sx;
        end
    end

    // first position above the sample, scanning from entry 1
    always_comb begin
        logic          found;
        logic [PW-1:0] first;
        found = 1'b0;
        first = '0;
        for (int j = MAX_POINTS - 1; j >= 1; j--) begin
            if (gt2_reg[j] && (j < 32'(n_eff))) begin
                found = 1'b1;
                first = PW'(j);
            end
        end
        last3_next = !found;
        i3_next    = found ? PW'(first - PW'(1)) : PW'(n_eff - CW'(1));
    end

    assign a1 = last3_reg ? i3_reg : PW'(i3_reg + PW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
        end else if (en) begin
            ctl2_reg <= in_ctl;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gt2_reg   <= gt2_next;
            sx2_reg   <= in_sx;
            x2_reg    <= in_x;
            idx2_reg  <= in_idx;
            i3_reg    <= i3_next;
            last3_reg <= last3_next;
            sx3_reg   <= sx2_reg;
            x3_reg    <= x2_reg;
            idx3_reg  <= idx2_reg;
            sx4_reg   <= sx3_reg;
            last4_reg <= last3_reg;
            dy5_reg   <= $signed({1'b0, yl4_reg}) - $signed({1'b0, yr4_reg});
            dx5_reg   <= $signed({1'b0, sx4_reg}) - $signed({1'b0, x0_4_reg});
            d5_reg    <= $signed({1'b0, x1_4_reg}) - $signed({1'b0, x0_4_reg});
            yr5_reg   <= yr4_reg;
            last5_reg <= last4_reg;
            num6_reg  <= dy5_reg * dx5_reg;
            d6_reg    <= d5_reg;
            yr6_reg   <= yr5_reg;
            last6_reg <= last5_reg;
        end
    end

    // breakpoint tables: one write, reads at i and i+1 (at i twice past the last point)
    always_ff @(posedge aclk) begin
        if (en) begin
            if (ctl3_reg.wr) begin
                x_mem[PW'(idx3_reg)]  <= x3_reg;
                yl_mem[PW'(idx3_reg)] <= y_left_s3;
                yr_mem[PW'(idx3_reg)] <= y_right_s3;
            end
            x0_4_reg <= x_mem[i3_reg];
            x1_4_reg <= x_mem[a1];
            yr4_reg  <= yr_mem[i3_reg];
            yl4_reg  <= yl_mem[a1];
        end
    end

    // divide set-up (magnitudes, sign, overflow), then a restoring divide
    // with one quotient bit per stage
    always_ff @(posedge aclk) begin
        logic [NUM_W-1:0] mag;
        logic [DX_W-1:0]  den;
        logic [NUM_W-1:0] dsh;
        mag = num6_reg[NUM_W-1] ? NUM_W'(-num6_reg) : NUM_W'(num6_reg);
        den = d6_reg[DX_W-1] ? DX_W'(-d6_reg) : DX_W'(d6_reg);
        if (!aresetn) begin
            for (int k = 0; k <= Q_W; k++) begin
                dctl_reg[k] <= '0;
            end
        end else if (en) begin
            dctl_reg[0] <= ctl6_reg;
            for (int k = 0; k < Q_W; k++) begin
                dctl_reg[k+1] <= dctl_reg[k];
            end
        end
        if (en) begin
            rem_reg[0]  <= mag;
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= num6_reg[NUM_W-1] ^ d6_reg[DX_W-1];
            sat_reg[0]  <= mag >= (NUM_W'(den) << Q_W);
            skip_reg[0] <= last6_reg || (d6_reg == '0);
            dyr_reg[0]  <= yr6_reg;
            for (int k = 0; k < Q_W; k++) begin
                dsh = NUM_W'(den_reg[k]) << (Q_W - 1 - k);
                if (rem_reg[k] >= dsh) begin
                    rem_reg[k+1] <= rem_reg[k] - dsh;
                    quo_reg[k+1] <= quo_reg[k] | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    quo_reg[k+1] <= quo_reg[k];
                end
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                skip_reg[k+1] <= skip_reg[k];
                dyr_reg[k+1]  <= dyr_reg[k];
            end
        end
    end

    // add to y_right and clamp to a byte
    always_comb begin
        logic [Q_W:0]          qmag;
        logic signed [V_W-1:0] q;
        logic signed [V_W-1:0] v;
        qmag = sat_reg[Q_W] ? ((Q_W+1)'(1) << Q_W) : {1'b0, quo_reg[Q_W]};
        if (skip_reg[Q_W]) begin
            q = '0;
        end else if (neg_reg[Q_W]) begin
            q = -$signed(V_W'(qmag));
        end else begin
            q = $signed(V_W'(qmag));
        end
        v = $signed(V_W'(dyr_reg[Q_W])) + q;
        if (v[V_W-1]) begin
            byte_next = '0;
        end else if (v[V_W-2:Y_W] != '0) begin
            byte_next = '1;
        end else begin
            byte_next = v[Y_W-1:FRAC_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctlo_reg <= '0;
        end else if (en) begin
            ctlo_reg <= dctl_reg[Q_W];
        end
        if (en) begin
            byte_reg <= byte_next;
        end
    end

    assign out_ctl  = ctlo_reg;
    assign out_byte = byte_reg;

endmodule

`default_nettype wire
